>>> rtl/lintt_pkg.sv
package lintt_pkg;

  localparam int PolyLen = 256;
  localparam int Lanes = 4;
  localparam int Groups = PolyLen / Lanes;
  localparam logic signed [23:0] MOD_Q = 24'sd8380417;
  localparam logic [31:0] MOD_QINV = 32'd58728449;
  localparam logic signed [23:0] SCALE_F = 24'sd41978;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_RD, ST_EX, ST_M1, ST_M2, ST_M3, ST_WB,
    ST_ORD0, ST_ORD1, ST_OCAP
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       load_wr;
    logic       rd;
    logic       ex;
    logic       m1;
    logic       m2;
    logic       m3;
    logic       wb;
    logic       ord0;
    logic       ord1;
    logic       ocap;
    logic       scale;
    logic       last;
    logic [2:0] layer;
    logic [7:0] idx;
  } cmd_t;

  localparam int ZETA [0:255] = '{
         0,    25847, -2608894,  -518909,   237124,  -777960,  -876248,   466468,
   1826347,  2353451,  -359251, -2091905,  3119733, -2884855,  3111497,  2680103,
   2725464,  1024112, -1079900,  3585928,  -549488, -1119584,  2619752, -2108549,
  -2118186, -3859737, -1399561, -3277672,  1757237,   -19422,  4010497,   280005,
   2706023,    95776,  3077325,  3530437, -1661693, -3592148, -2537516,  3915439,
  -3861115, -3043716,  3574422, -2867647,  3539968,  -300467,  2348700,  -539299,
  -1699267, -1643818,  3505694, -3821735,  3507263, -2140649, -1600420,  3699596,
    811944,   531354,   954230,  3881043,  3900724, -2556880,  2071892, -2797779,
  -3930395, -1528703, -3677745, -3041255, -1452451,  3475950,  2176455, -1585221,
  -1257611,  1939314, -4083598, -1000202, -3190144, -3157330, -3632928,   126922,
   3412210,  -983419,  2147896,  2715295, -2967645, -3693493,  -411027, -2477047,
   -671102, -1228525,   -22981, -1308169,  -381987,  1349076,  1852771, -1430430,
  -3343383,   264944,   508951,  3097992,    44288, -1100098,   904516,  3958618,
  -3724342,    -8578,  1653064, -3249728,  2389356,  -210977,   759969, -1316856,
    189548, -3553272,  3159746, -1851402, -2409325,  -177440,  1315589,  1341330,
   1285669, -1584928,  -812732, -1439742, -3019102, -3881060, -3628969,  3839961,
   2091667,  3407706,  2316500,  3817976, -3342478,  2244091, -2446433, -3562462,
    266997,  2434439, -1235728,  3513181, -3520352, -3759364, -1197226, -3193378,
    900702,  1859098,   909542,   819034,   495491, -1613174,   -43260,  -522500,
   -655327, -3122442,  2031748,  3207046, -3556995,  -525098,  -768622, -3595838,
    342297,   286988, -2437823,  4108315,  3437287, -3342277,  1735879,   203044,
   2842341,  2691481, -2590150,  1265009,  4055324,  1247620,  2486353,  1595974,
  -3767016,  1250494,  2635921, -3548272, -2994039,  1869119,  1903435, -1050970,
  -1333058,  1237275, -3318210, -1430225,  -451100,  1312455,  3306115, -1962642,
  -1279661,  1917081, -2546312, -1374803,  1500165,   777191,  2235880,  3406031,
   -542412, -2831860, -1671176, -1846953, -2584293, -3724270,   594136, -3776993,
  -2013608,  2432395,  2454455,  -164721,  1957272,  3369112,   185531, -1207385,
  -3183426,   162844,  1616392,  3014001,   810149,  1652634, -3694233, -1799107,
  -3038916,  3523897,  3866901,   269760,  2213111,  -975884,  1717735,   472078,
   -426683,  1723600, -1803090,  1910376, -1667432, -1104333,  -260646, -3833893,
  -2939036, -2235985,  -420899, -2286327,   183443,  -976891,  1612842, -3545687,
   -554416,  3919660,   -48306, -1362209,  3937738,  1400424,  -846154,  1976782
  };

endpackage

>>> rtl/lintt_ctrl.sv
module lintt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output lintt_pkg::cmd_t     cmd
);
  import lintt_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] lane_r, lane_nxt;
  logic [5:0] grp_r, grp_nxt;
  logic [2:0] layer_r, layer_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic       scale_r, scale_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lane_r  <= '0;
      grp_r   <= '0;
      layer_r <= '0;
      idx_r   <= '0;
      scale_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
      grp_r   <= grp_nxt;
      layer_r <= layer_nxt;
      idx_r   <= idx_nxt;
      scale_r <= scale_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lane_nxt  = lane_r;
    grp_nxt   = grp_r;
    layer_nxt = layer_r;
    idx_nxt   = idx_r;
    scale_nxt = scale_r;
    cmd       = '0;
    cmd.scale = scale_r;
    cmd.layer = layer_r;
    cmd.idx   = idx_r;
    cmd.last  = (idx_r[7:2] == 6'(Groups - 1));
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          lane_nxt    = '0;
          state_nxt   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
        cmd.idx     = {grp_r, lane_r};
        lane_nxt    = lane_r + 2'd1;
        if (lane_r == 2'd3) begin
          if (grp_r == 6'(Groups - 1)) begin
            grp_nxt   = '0;
            layer_nxt = '0;
            idx_nxt   = '0;
            scale_nxt = 1'b0;
            state_nxt = ST_RD;
          end else begin
            grp_nxt   = grp_r + 6'd1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EX;
      end
      ST_EX: begin
        cmd.ex    = 1'b1;
        state_nxt = ST_M1;
      end
      ST_M1: begin
        cmd.m1    = 1'b1;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        cmd.m2    = 1'b1;
        state_nxt = ST_M3;
      end
      ST_M3: begin
        cmd.m3    = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = ST_RD;
        if (!scale_r) begin
          if (idx_r == 8'd127) begin
            idx_nxt = '0;
            if (layer_r == 3'd7) scale_nxt = 1'b1;
            else layer_nxt = layer_r + 3'd1;
          end else begin
            idx_nxt = idx_r + 8'd1;
          end
        end else begin
          if (idx_r == 8'd255) begin
            idx_nxt   = '0;
            state_nxt = ST_ORD0;
          end else begin
            idx_nxt = idx_r + 8'd1;
          end
        end
      end
      ST_ORD0: begin
        cmd.ord0  = 1'b1;
        state_nxt = ST_ORD1;
      end
      ST_ORD1: begin
        cmd.ord1  = 1'b1;
        state_nxt = ST_OCAP;
      end
      ST_OCAP: begin
        cmd.ocap = 1'b1;
        if (cmd.last) begin
          scale_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + 8'd4;
          state_nxt = ST_ORD0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/lintt_dp.sv
module lintt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  lintt_pkg::cmd_t     cmd,
  input  logic signed [31:0]  in_coeff0,
  input  logic signed [31:0]  in_coeff1,
  input  logic signed [31:0]  in_coeff2,
  input  logic signed [31:0]  in_coeff3,
  output logic                out_valid,
  output logic signed [23:0]  out_out0,
  output logic signed [23:0]  out_out1,
  output logic signed [23:0]  out_out2,
  output logic signed [23:0]  out_out3,
  output logic                out_last_group
);
  import lintt_pkg::*;

  logic [31:0] mem [0:PolyLen-1];
  logic [31:0] in_r [0:3];
  logic [31:0] rd_a_r, rd_b_r;
  logic signed [23:0] zeta_r;
  logic signed [31:0] mul_a_r;
  logic signed [23:0] mul_b_r;
  logic signed [55:0] prod_r;
  logic signed [31:0] t_r;
  logic signed [55:0] tq_r;
  logic        valid_r, last_r;
  logic [23:0] o0_r, o1_r, o2_r, o3_r;

  logic [7:0] bb, mask, xaddr, yaddr, kidx, rd_addr_a, rd_addr_b, wr_addr;
  logic [31:0] wr_data, sum, diff;
  logic        wr_en;
  logic [63:0] tfull;
  logic signed [56:0] dfull;

  always_comb begin
    bb    = {1'b0, cmd.idx[6:0]};
    mask  = (8'd1 << cmd.layer) - 8'd1;
    xaddr = (((bb >> cmd.layer) << (cmd.layer + 3'd1)) | (bb & mask));
    yaddr = xaddr | (8'd1 << cmd.layer);
    kidx  = 8'((9'd256 >> cmd.layer) - 9'd1 - 9'(bb >> cmd.layer));
    sum   = rd_a_r + rd_b_r;
    diff  = rd_a_r - rd_b_r;
    tfull = 64'(prod_r[31:0]) * 64'(MOD_QINV);
    dfull = 57'(prod_r) - 57'(tq_r);
    rd_addr_a = cmd.scale ? cmd.idx : xaddr;
    rd_addr_b = yaddr;
    if (cmd.ord0) begin
      rd_addr_a = cmd.idx;
      rd_addr_b = cmd.idx + 8'd1;
    end else if (cmd.ord1) begin
      rd_addr_a = cmd.idx + 8'd2;
      rd_addr_b = cmd.idx + 8'd3;
    end
    wr_en   = 1'b0;
    wr_addr = cmd.idx;
    wr_data = in_r[cmd.idx[1:0]];
    if (cmd.load_wr) begin
      wr_en = 1'b1;
    end else if (cmd.ex && !cmd.scale) begin
      wr_en   = 1'b1;
      wr_addr = xaddr;
      wr_data = sum;
    end else if (cmd.wb) begin
      wr_en   = 1'b1;
      wr_addr = cmd.scale ? cmd.idx : yaddr;
      wr_data = 32'(signed'(dfull[55:32]));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd || cmd.ord0 || cmd.ord1) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r[0] <= in_coeff0;
      in_r[1] <= in_coeff1;
      in_r[2] <= in_coeff2;
      in_r[3] <= in_coeff3;
    end
    if (cmd.rd) zeta_r <= 24'(ZETA[kidx]);
    if (cmd.ex) begin
      mul_a_r <= cmd.scale ? rd_a_r : diff;
      mul_b_r <= cmd.scale ? SCALE_F : -zeta_r;
    end
    if (cmd.m1) prod_r <= 56'(mul_a_r) * 56'(mul_b_r);
    if (cmd.m2) t_r <= tfull[31:0];
    if (cmd.m3) tq_r <= 56'(t_r) * 56'(MOD_Q);
    if (cmd.ord1) begin
      o0_r <= rd_a_r[23:0];
      o1_r <= rd_b_r[23:0];
    end
    if (cmd.ocap) begin
      o2_r <= rd_a_r[23:0];
      o3_r <= rd_b_r[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      valid_r <= cmd.ocap;
      last_r  <= cmd.ocap && cmd.last;
    end
  end

  assign out_valid      = valid_r;
  assign out_last_group = last_r;
  assign out_out0       = o0_r;
  assign out_out1       = o1_r;
  assign out_out2       = o2_r;
  assign out_out3       = o3_r;

endmodule

>>> rtl/lattice_inverse_ntt.sv
// Inverse NTT, modulus 8380417, 256 coefficients in groups of four.
// Input: a transfer happens on a rising edge with start high and busy low;
//   in_coeff0..3 carry four consecutive 32-bit coefficients in order.
//   Each group is accepted, then written to the store in four single-port writes.
// After the 64th group the block runs eight Gentleman-Sande layers and a
//   scaling pass through one shared butterfly/Montgomery datapath:
//   each butterfly steps through read, add/sub, three multiplies and write back;
//   1024 butterflies plus 256 scalings in all.
// Output: 64 groups, each from two 2-port store reads;
//   out_valid marks each transfer for one cycle, out_last_group the final
//   one. busy is high during the store writes after each accept; after
//   the 64th group it stays high until the cycle the last result appears.
// The receiver cannot stall; results are always taken.
// Reset (rst_n low, synchronous) returns to idle with no groups loaded;
//   the coefficient store needs no clearing.
module lattice_inverse_ntt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_coeff0,
  input  logic signed [31:0] in_coeff1,
  input  logic signed [31:0] in_coeff2,
  input  logic signed [31:0] in_coeff3,
  output logic               out_valid,
  output logic signed [23:0] out_out0,
  output logic signed [23:0] out_out1,
  output logic signed [23:0] out_out2,
  output logic signed [23:0] out_out3,
  output logic               out_last_group
);
  import lintt_pkg::*;

  cmd_t cmd;

  lintt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lintt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_coeff0      (in_coeff0),
    .in_coeff1      (in_coeff1),
    .in_coeff2      (in_coeff2),
    .in_coeff3      (in_coeff3),
    .out_valid      (out_valid),
    .out_out0       (out_out0),
    .out_out1       (out_out1),
    .out_out2       (out_out2),
    .out_out3       (out_out3),
    .out_last_group (out_last_group)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after transfer");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back result strobes");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_group |-> !busy) else $error("busy after last group");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_group |-> out_valid) else $error("last flag without strobe");

endmodule

>>> tb/tb_lattice_inverse_ntt.sv
module tb_lattice_inverse_ntt;
  timeunit 1ns;
  timeprecision 1ps;
  import lintt_pkg::*;

  typedef struct {
    logic signed [31:0] c [4];
    bit                 hold;
  } group_in_t;

  typedef struct {
    logic signed [23:0] c [4];
    logic               last;
  } group_out_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_coeff0 = '0;
  logic signed [31:0] in_coeff1 = '0;
  logic signed [31:0] in_coeff2 = '0;
  logic signed [31:0] in_coeff3 = '0;
  logic               out_valid;
  logic signed [23:0] out_out0;
  logic signed [23:0] out_out1;
  logic signed [23:0] out_out2;
  logic signed [23:0] out_out3;
  logic               out_last_group;

  group_in_t  pend_q [$];
  group_out_t poly_out_q [$];
  logic signed [31:0] poly_buf [PolyLen];
  int  groups_in = 0;
  int  n_sent = 0;
  int  n_groups_out = 0;
  int  n_polys = 0;
  int  errors = 0;
  bit  xfer_seen = 0;
  bit  stim_done = 0;

  always #5 clk = ~clk;

  lattice_inverse_ntt i_dut (
    .clk, .rst_n, .start, .busy,
    .in_coeff0, .in_coeff1, .in_coeff2, .in_coeff3,
    .out_valid, .out_out0, .out_out1, .out_out2, .out_out3, .out_last_group
  );

  function automatic logic signed [31:0] mont_reduce(longint a);
    logic [31:0] t;
    longint      d;
    t = a[31:0] * MOD_QINV;
    d = a - longint'($signed(t)) * 64'sd8380417;
    return 32'(d >>> 32);
  endfunction

  function automatic void run_inverse_ntt();
    int k;
    logic signed [31:0] x, y, diff;
    longint zeta;
    k = 256;
    for (int len = 1; len < PolyLen; len = len * 2) begin
      for (int s = 0; s < PolyLen; s += 2 * len) begin
        k--;
        zeta = -longint'(ZETA[k]);
        for (int j = s; j < s + len; j++) begin
          x = poly_buf[j];
          y = poly_buf[j + len];
          diff = x - y;
          poly_buf[j] = x + y;
          poly_buf[j + len] = mont_reduce(longint'(diff) * zeta);
        end
      end
    end
    for (int j = 0; j < PolyLen; j++)
      poly_buf[j] = mont_reduce(longint'(poly_buf[j]) * 41978);
  endfunction

  function automatic void load_group(group_in_t g);
    group_out_t r;
    for (int i = 0; i < Lanes; i++) poly_buf[groups_in * Lanes + i] = g.c[i];
    groups_in++;
    if (groups_in == Groups) begin
      groups_in = 0;
      run_inverse_ntt();
      for (int n = 0; n < Groups; n++) begin
        for (int i = 0; i < Lanes; i++) r.c[i] = poly_buf[n * Lanes + i][23:0];
        r.last = (n == Groups - 1);
        poly_out_q.push_back(r);
      end
    end
  endfunction

  // driver
  always @(negedge clk) begin
    logic nxt;
    int   gap_pct;
    nxt = 1'b0;
    gap_pct = (n_sent < 128) ? 20 : (n_sent < 256) ? 67 : 0;
    if (!rst_n) begin
      nxt = 1'b0;
    end else if (start && !xfer_seen) begin
      nxt = 1'b1;
    end else if (pend_q.size() > 0 && !(pend_q[0].hold && poly_out_q.size() > 0)
                 && $urandom_range(99) >= gap_pct) begin
      nxt = 1'b1;
      in_coeff0 <= pend_q[0].c[0];
      in_coeff1 <= pend_q[0].c[1];
      in_coeff2 <= pend_q[0].c[2];
      in_coeff3 <= pend_q[0].c[3];
    end
    xfer_seen = 0;
    start <= nxt;
  end

  // monitor
  always @(posedge clk) begin
    group_out_t e;
    logic signed [23:0] act [4];
    if (rst_n) begin
      if (start && !busy) begin
        load_group(pend_q.pop_front());
        n_sent++;
        xfer_seen = 1;
      end
      if (out_valid) begin
        act = '{out_out0, out_out1, out_out2, out_out3};
        if (poly_out_q.size() == 0) begin
          $display("%0t: unexpected result group", $time);
          errors++;
        end else begin
          e = poly_out_q.pop_front();
          for (int i = 0; i < Lanes; i++)
            if (act[i] !== e.c[i]) begin
              $display("%0t: out%0d expected %0d actual %0d", $time, i, e.c[i], act[i]);
              errors++;
            end
          if (out_last_group !== e.last) begin
            $display("%0t: last_group expected %0b actual %0b", $time, e.last,
                     out_last_group);
            errors++;
          end
          n_groups_out++;
          if (e.last) n_polys++;
        end
      end
    end
  end

  initial begin
    group_in_t g;
    logic signed [31:0] pat [8];
    pat = '{32'h7fffffff, 32'h80000000, 0, -1, 1, 8380417, -8380417, 32'h55555555};
    // polynomial 0: extremes first, remainder random
    for (int n = 0; n < Groups; n++) begin
      g.hold = 0;
      for (int i = 0; i < Lanes; i++)
        g.c[i] = (n < 16) ? pat[(n + i * (n / 8 + 1)) % 8] : $urandom;
      pend_q.push_back(g);
    end
    for (int p = 1; p < 6; p++) begin
      for (int n = 0; n < Groups; n++) begin
        g.hold = (p == 3 && n == 0);
        for (int i = 0; i < Lanes; i++)
          case ($urandom_range(3))
            0: g.c[i] = $urandom_range(8380416);
            1: g.c[i] = -$signed($urandom_range(8380416));
            default: g.c[i] = $urandom;
          endcase
        pend_q.push_back(g);
      end
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait (pend_q.size() == 0 && poly_out_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("Covered %0d input groups and %0d result groups (%0d polynomials),",
             n_sent, n_groups_out, n_polys);
    $display("with extreme coefficients, random data and varied sender gaps.");
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
